### design/ppu_scroll_address_registers_macros.svh
// Assertion macros shared by the scroll and address register design.
`ifndef PPU_SCROLL_ADDRESS_REGISTERS_MACROS_SVH
`define PPU_SCROLL_ADDRESS_REGISTERS_MACROS_SVH

// Checks that a condition seen at one edge is followed by a consequence at the next edge.
`define PSAR_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("scroll register check failed");

// Checks that an implication holds within the same edge.
`define PSAR_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("scroll register check failed");

`endif

### design/psar_pkg.sv
// Package with event codes, bit field constants and the register state type.
package psar_pkg;

	localparam int unsigned ADDR_W = 15;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_CTRL   = 3'd0;
	localparam kind_t KIND_SCROLL = 3'd1;
	localparam kind_t KIND_ADDR   = 3'd2;
	localparam kind_t KIND_STATUS = 3'd3;
	localparam kind_t KIND_DATA   = 3'd4;
	localparam kind_t KIND_INC_X  = 3'd5;
	localparam kind_t KIND_INC_Y  = 3'd6;

	localparam logic [ADDR_W-1:0] SCROLL_KEEP  = 15'h0C1F;
	localparam logic [ADDR_W-1:0] NT_SEL_CLEAR = 15'h73FF;
	localparam logic [ADDR_W-1:0] STEP_ROW     = 15'd32;
	localparam logic [ADDR_W-1:0] STEP_ONE     = 15'd1;
	localparam logic [4:0]        COARSE_LAST  = 5'd31;
	localparam logic [4:0]        ROW_LAST     = 5'd29;
	localparam logic [2:0]        FINE_Y_LAST  = 3'd7;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		addr_t      cur;
		addr_t      tmp;
		logic [2:0] fine_x;
		logic       toggle;
		logic       step_by_row;
	} scroll_state_t;

endpackage

### design/ppu_scroll_address_registers.sv
// Scroll and address registers of the picture unit: current and temporary address, fine X.
//
// The input channel (in_valid, in_ready, kind, data_byte) carries one event word per
// handshake: a control write, one phase of a scroll or address write, a status read,
// a data-port access, or a rendering coarse-X or Y increment. The output channel
// (out_valid, out_ready, vram_address, temp_address, fine_x_out, second_phase) returns
// one word per event with the registers as they stand after that event.
// An accepted event is registered in the input stage; once the result slot is free or
// being emptied, the short update logic loads the register file, which also serves as
// the result register, and out_valid rises with it. Throughput is one event per cycle
// as long as the receiver takes each result word; the register file is the only loop.
// When the receiver stalls, the result word is held and one more event is still taken
// into the input register; in_ready drops only when both stages are full.
// Reset clears all addresses, fine X, the write toggle and the increment mode, and
// empties both stages. Kind 7 leaves every register unchanged but still returns a word.
module ppu_scroll_address_registers (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  psar_pkg::kind_t       kind,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output psar_pkg::addr_t       vram_address,
	output psar_pkg::addr_t       temp_address,
	output logic [2:0]            fine_x_out,
	output logic                  second_phase
);
	import psar_pkg::*;

	`include "ppu_scroll_address_registers_macros.svh"

	// Input stage.
	logic       valid_s1;
	kind_t      kind_s1;
	logic [7:0] data_s1;

	// Register file; its contents are also the pending result word.
	scroll_state_t state_q;
	scroll_state_t state_nxt;
	logic          out_valid_q;

	logic advance;
	logic accept;

	// The input stage moves on when the result slot is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_CTRL;
			data_s1 <= 8'h00;
		end else if (accept) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
		end
	end

	// Event update logic.
	always_comb begin
		logic [4:0]  coarse_y;
		addr_t       tmp_lo;
		addr_t       sum;
		state_nxt = state_q;
		coarse_y  = state_q.cur[9:5];
		tmp_lo    = {state_q.tmp[14:8], data_s1};
		sum       = state_q.cur + (state_q.step_by_row ? STEP_ROW : STEP_ONE);
		unique case (kind_s1)
			KIND_CTRL: begin
				state_nxt.tmp         = (state_q.tmp & NT_SEL_CLEAR) |
					{3'b000, data_s1[1:0], 10'd0};
				state_nxt.step_by_row = data_s1[2];
			end
			KIND_SCROLL: begin
				if (state_q.toggle) begin
					state_nxt.tmp = (state_q.tmp & SCROLL_KEEP) |
						{data_s1[2:0], 2'b00, data_s1[7:3], 5'd0};
				end else begin
					state_nxt.fine_x    = data_s1[2:0];
					state_nxt.tmp[4:0]  = data_s1[7:3];
				end
				state_nxt.toggle = !state_q.toggle;
			end
			KIND_ADDR: begin
				if (state_q.toggle) begin
					state_nxt.tmp = tmp_lo;
					// The current address drops bit 14 of the temporary one.
					state_nxt.cur = {1'b0, tmp_lo[13:0]};
				end else begin
					state_nxt.tmp = {1'b0, data_s1[5:0], state_q.tmp[7:0]};
				end
				state_nxt.toggle = !state_q.toggle;
			end
			KIND_STATUS: begin
				state_nxt.toggle = 1'b0;
			end
			KIND_DATA: begin
				state_nxt.cur = {1'b0, sum[13:0]};
			end
			KIND_INC_X: begin
				if (state_q.cur[4:0] == COARSE_LAST) begin
					state_nxt.cur[4:0] = 5'd0;
					state_nxt.cur[10]  = !state_q.cur[10];
				end else begin
					state_nxt.cur[4:0] = state_q.cur[4:0] + 5'd1;
				end
			end
			KIND_INC_Y: begin
				if (state_q.cur[14:12] != FINE_Y_LAST) begin
					state_nxt.cur[14:12] = state_q.cur[14:12] + 3'd1;
				end else begin
					state_nxt.cur[14:12] = 3'd0;
					// Row 29 is the last visible row and switches the vertical table;
					// row 31 wraps without switching, and row 30 simply steps to 31.
					priority if (coarse_y == ROW_LAST) begin
						state_nxt.cur[9:5] = 5'd0;
						state_nxt.cur[11]  = !state_q.cur[11];
					end else if (coarse_y == COARSE_LAST) begin
						state_nxt.cur[9:5] = 5'd0;
					end else begin
						state_nxt.cur[9:5] = coarse_y + 5'd1;
					end
				end
			end
			default: begin
				state_nxt = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign vram_address = state_q.cur;
	assign temp_address = state_q.tmp;
	assign fine_x_out   = state_q.fine_x;
	assign second_phase = state_q.toggle;

	`PSAR_ASSERT_NEXT(a_status_clears_toggle, advance && kind_s1 == KIND_STATUS, !state_q.toggle)
	`PSAR_ASSERT_NEXT(a_write_flips_toggle,
		advance && (kind_s1 == KIND_SCROLL || kind_s1 == KIND_ADDR),
		state_q.toggle != $past(state_q.toggle))
	`PSAR_ASSERT_NEXT(a_data_access_wraps, advance && kind_s1 == KIND_DATA, !state_q.cur[14])
	`PSAR_ASSERT_NEXT(a_result_follows_advance, advance, out_valid_q)
	`PSAR_ASSERT_SAME(a_no_overwrite_pending, out_valid_q && !out_ready, !advance)

endmodule

### tb/sv/psar_scoreboard.sv
// Scoreboard for the scroll and address registers: it predicts each result word and checks it.
module psar_scoreboard
	import psar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  kind_t       kind,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  addr_t       vram_address,
	input  addr_t       temp_address,
	input  logic [2:0]  fine_x_out,
	input  logic        second_phase,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	scroll_state_t regs = '0;
	scroll_state_t predicted_regs_q[$];
	int unsigned   error_total = 0;
	int unsigned   pending_words = 0;

	assign fail_count  = error_total;
	assign outstanding = pending_words;

	// Applies one event to the register set and returns the registers after it.
	function automatic scroll_state_t advance_registers(scroll_state_t s, kind_t k,
			logic [7:0] d);
		logic [4:0] row;
		case (k)
			KIND_CTRL: begin
				s.tmp[11:10]  = d[1:0];
				s.step_by_row = d[2];
			end
			KIND_SCROLL: begin
				if (s.toggle) begin
					s.tmp[9:5]   = d[7:3];
					s.tmp[14:12] = d[2:0];
				end else begin
					s.fine_x   = d[2:0];
					s.tmp[4:0] = d[7:3];
				end
				s.toggle = ~s.toggle;
			end
			KIND_ADDR: begin
				if (s.toggle) begin
					s.tmp[7:0] = d;
					s.cur      = {1'b0, s.tmp[13:0]};
				end else begin
					s.tmp[13:8] = d[5:0];
					s.tmp[14]   = 1'b0;
				end
				s.toggle = ~s.toggle;
			end
			KIND_STATUS: s.toggle = 1'b0;
			KIND_DATA: begin
				s.cur = s.cur + (s.step_by_row ? STEP_ROW : STEP_ONE);
				s.cur[14] = 1'b0;
			end
			KIND_INC_X: begin
				if (s.cur[4:0] == COARSE_LAST) begin
					s.cur[4:0] = '0;
					s.cur[10]  = ~s.cur[10];
				end else begin
					s.cur[4:0] = s.cur[4:0] + 5'd1;
				end
			end
			KIND_INC_Y: begin
				if (s.cur[14:12] != FINE_Y_LAST) begin
					s.cur[14:12] = s.cur[14:12] + 3'd1;
				end else begin
					s.cur[14:12] = '0;
					row = s.cur[9:5];
					if (row == ROW_LAST) begin
						row       = '0;
						s.cur[11] = ~s.cur[11];
					end else if (row == COARSE_LAST) begin
						row = '0;
					end else begin
						row = row + 5'd1;
					end
					s.cur[9:5] = row;
				end
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t ns: %s mismatch, got %h, predicted %h", $time, what, got, want);
		error_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		scroll_state_t want;
		if (!arst_n) begin
			regs = '0;
			predicted_regs_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_regs_q.size() == 0) begin
					report_mismatch("unpredicted word, vram address", 32'(vram_address), 0);
				end else begin
					want = predicted_regs_q.pop_front();
					if (vram_address !== want.cur)
						report_mismatch("vram address", 32'(vram_address), 32'(want.cur));
					if (temp_address !== want.tmp)
						report_mismatch("temp address", 32'(temp_address), 32'(want.tmp));
					if (fine_x_out !== want.fine_x)
						report_mismatch("fine x", 32'(fine_x_out), 32'(want.fine_x));
					if (second_phase !== want.toggle)
						report_mismatch("write toggle", 32'(second_phase), 32'(want.toggle));
				end
			end
			if (in_valid && in_ready) begin
				regs = advance_registers(regs, kind, data_byte);
				predicted_regs_q.push_back(regs);
			end
		end
		pending_words = predicted_regs_q.size();
	end

endmodule

### tb/sv/tb_ppu_scroll_address_registers.sv
// Top of the scroll and address register testbench: clock, reset, event stimulus and verdict.
module tb_ppu_scroll_address_registers;
	import psar_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Kind 7 has no name in the package; the block must leave every register alone for it.
	localparam kind_t KIND_UNUSED = 3'd7;

	// This bound leaves a wide margin for a word even at the heaviest idling.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          RANDOM_WORDS_PER_PHASE = 125;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	kind_t       kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	addr_t       vram_address;
	addr_t       temp_address;
	logic [2:0]  fine_x_out;
	logic        second_phase;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int          words_sent = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	ppu_scroll_address_registers dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vram_address (vram_address),
		.temp_address (temp_address),
		.fine_x_out   (fine_x_out),
		.second_phase (second_phase)
	);

	psar_scoreboard scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vram_address (vram_address),
		.temp_address (temp_address),
		.fine_x_out   (fine_x_out),
		.second_phase (second_phase),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver decides afresh every cycle whether it takes a result word.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one event word. The task is entered just after a rising edge. Idle cycles
	// come first, each decided on its own, so gaps land anywhere in a sequence of
	// events. Once valid is up it stays up, with the word unchanged, until the edge at
	// which in_ready is seen high. The task returns just after that edge, so the next
	// call may keep valid high without lowering it in between.
	task automatic send_word(kind_t k, logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= d;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// The rendering increments and the data port all move the current address.
	function automatic kind_t pick_address_mover();
		case ($urandom_range(2))
			0:       return KIND_DATA;
			1:       return KIND_INC_X;
			default: return KIND_INC_Y;
		endcase
	endfunction

	// Most of the random traffic is made of well-formed register sequences: an address
	// write pair followed by a run of increments walks the current address through its
	// wrap points, and scroll pairs fill the temporary address. The rest is single
	// control writes, sequences that a status read breaks off halfway, and plain noise
	// that may use any kind, the unused one too.
	task automatic send_random_words(int count);
		int stop_at;
		int run_len;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					send_word(KIND_ADDR, 8'($urandom_range(255)));
					send_word(KIND_ADDR, 8'($urandom_range(255)));
					run_len = $urandom_range(1, 20);
					repeat (run_len) send_word(pick_address_mover(), 8'($urandom_range(255)));
				end
				3, 4: begin
					if ($urandom_range(1))
						send_word(KIND_STATUS, 8'($urandom_range(255)));
					send_word(KIND_SCROLL, 8'($urandom_range(255)));
					send_word(KIND_SCROLL, 8'($urandom_range(255)));
				end
				5: send_word(KIND_CTRL, 8'($urandom_range(255)));
				6: begin
					send_word($urandom_range(1) ? KIND_ADDR : KIND_SCROLL,
						8'($urandom_range(255)));
					send_word(KIND_STATUS, 8'($urandom_range(255)));
				end
				default: send_word(kind_t'($urandom_range(7)), 8'($urandom_range(255)));
			endcase
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_CTRL;
		data_byte <= 8'h00;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling on either side.
		// The unused kind must return the reset registers untouched.
		send_word(KIND_UNUSED, 8'hFF);
		// Every scroll and select bit set: the temporary address fills to all ones,
		// and the first address write clears its top bit again.
		send_word(KIND_CTRL, 8'hFF);
		send_word(KIND_SCROLL, 8'hFF);
		send_word(KIND_SCROLL, 8'hFF);
		send_word(KIND_ADDR, 8'hFF);
		send_word(KIND_ADDR, 8'hFF);
		// A step of 32 from the top of the space wraps around modulo 0x4000.
		send_word(KIND_DATA, 8'hFF);
		send_word(KIND_CTRL, 8'h00);
		// A status read in the middle of a scroll pair restarts it at the first phase.
		send_word(KIND_SCROLL, 8'h00);
		send_word(KIND_STATUS, 8'hFF);
		send_word(KIND_SCROLL, 8'h00);
		send_word(KIND_SCROLL, 8'h00);
		// Coarse X at its last column wraps and flips the horizontal select bit.
		send_word(KIND_ADDR, 8'h00);
		send_word(KIND_ADDR, 8'h1F);
		send_word(KIND_INC_X, 8'hFF);
		send_word(KIND_DATA, 8'h00);
		// Row 29 with fine Y at 3: four Y increments reach the end of the tile, and the
		// fifth wraps the row and flips the vertical select bit.
		send_word(KIND_ADDR, 8'h33);
		send_word(KIND_ADDR, 8'hA0);
		repeat (5) send_word(KIND_INC_Y, 8'h00);
		send_word(KIND_STATUS, 8'h00);

		// Random part in four idling phases.
		send_random_words(RANDOM_WORDS_PER_PHASE);
		send_idle_pct  <= 77;
		recv_stall_pct <= 0;
		send_random_words(RANDOM_WORDS_PER_PHASE);
		send_idle_pct  <= 0;
		recv_stall_pct <= 77;
		send_random_words(RANDOM_WORDS_PER_PHASE);
		send_idle_pct  <= 34;
		recv_stall_pct <= 34;
		send_random_words(RANDOM_WORDS_PER_PHASE);
		in_valid <= 1'b0;

		// An edge first lets the last acceptance reach the scoreboard before it is asked
		// whether words are still in flight; a last wait then catches any extra word.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
